// File: design/aes_ke_pkg.sv
package aes_ke_pkg;

  // AES forward S-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // key length codes
  localparam logic [1:0] KEY_LEN_128 = 2'd0;
  localparam logic [1:0] KEY_LEN_192 = 2'd1;

  localparam int unsigned WordW   = 32;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned WindowN = 8;

  // last key-word index (Nk - 1) and last schedule index per key length
  localparam logic [2:0] NK_LAST_128 = 3'd3;
  localparam logic [2:0] NK_LAST_192 = 3'd5;
  localparam logic [2:0] NK_LAST_256 = 3'd7;
  localparam logic [IndexW-1:0] IDX_LAST_128 = 6'd43;
  localparam logic [IndexW-1:0] IDX_LAST_192 = 6'd51;
  localparam logic [IndexW-1:0] IDX_LAST_256 = 6'd59;

  // slot at which a 256-bit key takes the extra SubWord
  localparam logic [2:0] SLOT_SUB_ONLY = 3'd4;
  localparam logic [7:0] RCON_INIT     = 8'h01;
  localparam logic [7:0] RCON_POLY     = 8'h1b;

  typedef enum logic {
    ST_LOAD,
    ST_EXPAND
  } state_e;

  // controls for the word unit
  typedef struct packed {
    logic       rot_sub;
    logic       sub_only;
    logic [7:0] rcon;
  } word_ctrl_t;

endpackage

// File: design/aes_ke_word_unit.sv
module aes_ke_word_unit (
  input  aes_ke_pkg::word_ctrl_t ctrl_i,
  input  logic [31:0]            prev_i,
  input  logic [31:0]            oldest_i,
  output logic [31:0]            word_o
);
  import aes_ke_pkg::*;

  logic [31:0] sub_in;
  logic [31:0] sub_out;
  logic [31:0] xform;

  assign sub_in = ctrl_i.rot_sub ? {prev_i[23:0], prev_i[31:24]} : prev_i;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      sub_out[b*8 +: 8] = SBOX[sub_in[b*8 +: 8]];
    end
  end

  always_comb begin
    priority if (ctrl_i.rot_sub) begin
      xform = sub_out ^ {ctrl_i.rcon, 24'h000000};
    end else if (ctrl_i.sub_only) begin
      xform = sub_out;
    end else begin
      xform = prev_i;
    end
  end

  assign word_o = oldest_i ^ xform;

endmodule

// File: design/aes_key_expansion.sv
// Channel  | Direction | Handshake               | Payload
// key word | in        | start_i & !busy_o       | key_word_i
// result   | out       | result_valid_o          | round_key_word_o, word_index_o, last_word_o
// config   | in        | key_length_we_i         | key_length_i
//
// Each key word is echoed in the cycle after it is taken; busy_o stays low while loading.
// On the final key word the block runs the word unit once per cycle, emitting
// 40, 46 or 52 derived words on consecutive cycles; busy_o is high throughout.
// A full key therefore takes Nk key-word loads followed by the expansion.
// Reset clears the sequencer, counters and key length; the receiver cannot stall.
module aes_key_expansion (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        key_length_we_i,
  input  logic [1:0]  key_length_i,
  input  logic        start_i,
  input  logic [31:0] key_word_i,
  output logic        busy_o,
  output logic        result_valid_o,
  output logic [31:0] round_key_word_o,
  output logic [5:0]  word_index_o,
  output logic        last_word_o
);
  import aes_ke_pkg::*;

  state_e state_q, state_d;

  logic [1:0]        key_length_q;
  logic [2:0]        loaded_q, loaded_d;
  logic [IndexW-1:0] idx_q, idx_d;
  logic [2:0]        slot_q, slot_d;
  logic [7:0]        rcon_q, rcon_d;
  logic [31:0]       window_q [WindowN];

  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_word_q, out_word_d;
  logic [IndexW-1:0] out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;

  logic              accept;
  logic              shift_en;
  logic [31:0]       shift_word;
  logic [2:0]        nk_last;
  logic [IndexW-1:0] idx_last;
  logic [31:0]       oldest;
  logic [31:0]       new_word;
  logic              exp_done;
  word_ctrl_t        ctrl;

  always_comb begin
    unique case (key_length_q)
      KEY_LEN_128: begin
        nk_last  = NK_LAST_128;
        idx_last = IDX_LAST_128;
        oldest   = window_q[NK_LAST_128];
      end
      KEY_LEN_192: begin
        nk_last  = NK_LAST_192;
        idx_last = IDX_LAST_192;
        oldest   = window_q[NK_LAST_192];
      end
      default: begin
        nk_last  = NK_LAST_256;
        idx_last = IDX_LAST_256;
        oldest   = window_q[NK_LAST_256];
      end
    endcase
  end

  assign accept   = start_i && (state_q == ST_LOAD);
  assign busy_o   = (state_q == ST_EXPAND);
  assign exp_done = (idx_q == idx_last);

  assign ctrl.rot_sub  = (slot_q == 3'd0);
  assign ctrl.sub_only = (nk_last == NK_LAST_256) && (slot_q == SLOT_SUB_ONLY);
  assign ctrl.rcon     = rcon_q;

  aes_ke_word_unit u_word_unit (
    .ctrl_i   (ctrl),
    .prev_i   (window_q[0]),
    .oldest_i (oldest),
    .word_o   (new_word)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept && (loaded_q == nk_last)) begin
          state_d = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (exp_done) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    loaded_d    = loaded_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    rcon_d      = rcon_q;
    shift_en    = 1'b0;
    shift_word  = key_word_i;
    out_valid_d = 1'b0;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          shift_en    = 1'b1;
          out_valid_d = 1'b1;
          out_word_d  = key_word_i;
          out_idx_d   = {{(IndexW-3){1'b0}}, loaded_q};
          out_last_d  = 1'b0;
          if (loaded_q == nk_last) begin
            loaded_d = 3'd0;
            idx_d    = {{(IndexW-3){1'b0}}, nk_last} + 1'b1;
            slot_d   = 3'd0;
          end else begin
            loaded_d = loaded_q + 3'd1;
          end
        end
      end
      ST_EXPAND: begin
        shift_en    = 1'b1;
        shift_word  = new_word;
        out_valid_d = 1'b1;
        out_word_d  = new_word;
        out_idx_d   = idx_q;
        out_last_d  = exp_done;
        idx_d       = idx_q + 1'b1;
        slot_d      = (slot_q == nk_last) ? 3'd0 : slot_q + 3'd1;
        if (ctrl.rot_sub) begin
          // advance Rcon by doubling in GF(2^8)
          rcon_d = {rcon_q[6:0], 1'b0} ^ (rcon_q[7] ? RCON_POLY : 8'h00);
        end
        if (exp_done) begin
          rcon_d = RCON_INIT;
        end
      end
      default: ;
    endcase
    // a length write restarts the key load
    if (key_length_we_i) begin
      loaded_d = 3'd0;
      rcon_d   = RCON_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      key_length_q <= KEY_LEN_128;
      loaded_q     <= 3'd0;
      idx_q        <= '0;
      slot_q       <= 3'd0;
      rcon_q       <= RCON_INIT;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      idx_q       <= idx_d;
      slot_q      <= slot_d;
      rcon_q      <= rcon_d;
      out_valid_q <= out_valid_d;
      if (key_length_we_i) begin
        key_length_q <= key_length_i;
      end
    end
  end

  // newest word at tap 0, word i-Nk at tap Nk-1
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      window_q[0] <= shift_word;
      for (int k = 1; k < WindowN; k++) begin
        window_q[k] <= window_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign result_valid_o   = out_valid_q;
  assign round_key_word_o = out_word_q;
  assign word_index_o     = out_idx_q;
  assign last_word_o      = out_last_q;

endmodule
